>>> hdl/utf8s_pkg.sv
package utf8s_pkg;

   localparam logic [7:0] SUB_CHAR   = 8'h3F;
   localparam int         HOLD_DEPTH = 3;
   localparam int         GROUP_MAX  = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // Result bytes caused by one input transfer, oldest in entry 0
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      fin;
   } group_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if ((b & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

>>> hdl/utf8s_core.sv
module utf8s_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  utf8s_pkg::req_type  req,
   output utf8s_pkg::group_type grp
);

   logic [7:0] pending_ff [utf8s_pkg::HOLD_DEPTH];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [2:0] seq_len_ff;
   logic [2:0] seq_len_in;
   logic       write_en;
   logic [1:0] write_idx;

   logic [7:0] b;
   logic       fin;
   logic       cont;
   logic       holding;
   logic [2:0] lead_len;
   logic [2:0] cnt_ext;
   logic [2:0] pre;
   logic [7:0] tail;
   logic       tail_held;

   assign b        = req.in_byte;
   assign fin      = req.is_final;
   assign cont     = (b[7:6] == 2'b10);
   assign holding  = (seq_len_ff != 3'd0);
   assign lead_len = utf8s_pkg::lead_length(b);
   assign cnt_ext  = {1'b0, count_ff};

   always_comb begin
      grp.fin    = fin;
      grp.count  = 3'd0;
      grp.bytes  = {utf8s_pkg::GROUP_MAX{utf8s_pkg::SUB_CHAR}};
      count_in   = count_ff;
      seq_len_in = seq_len_ff;
      write_en   = 1'b0;
      write_idx  = count_ff;
      pre        = 3'd0;
      tail       = b;
      tail_held  = 1'b0;
      if (holding && cont) begin
         if (cnt_ext + 3'd1 == seq_len_ff) begin
            // complete sequence: replay held bytes, then this one
            for (int i = 0; i < utf8s_pkg::HOLD_DEPTH; i++) begin
               if (3'(i) < cnt_ext) begin
                  grp.bytes[i] = pending_ff[i];
               end else begin
                  grp.bytes[i] = b;
               end
            end
            grp.bytes[utf8s_pkg::GROUP_MAX-1] = b;
            grp.count  = cnt_ext + 3'd1;
            count_in   = 2'd0;
            seq_len_in = 3'd0;
         end else if (fin || count_ff == 2'd3) begin
            grp.count  = cnt_ext + 3'd1;
            count_in   = 2'd0;
            seq_len_in = 3'd0;
         end else begin
            write_en  = 1'b1;
            write_idx = count_ff;
            count_in  = count_ff + 2'd1;
         end
      end else begin
         // held bytes of a broken sequence become replacements
         if (holding) begin
            pre = cnt_ext;
         end
         count_in   = 2'd0;
         seq_len_in = 3'd0;
         if (b[7] == 1'b0) begin
            tail = b;
         end else if (lead_len != 3'd0 && !fin) begin
            tail_held  = 1'b1;
            write_en   = 1'b1;
            write_idx  = 2'd0;
            count_in   = 2'd1;
            seq_len_in = lead_len;
         end else begin
            tail = utf8s_pkg::SUB_CHAR;
         end
         for (int i = 0; i < utf8s_pkg::GROUP_MAX; i++) begin
            if (3'(i) == pre) begin
               grp.bytes[i] = tail;
            end
         end
         grp.count = tail_held ? pre : pre + 3'd1;
      end
      if (fin) begin
         count_in   = 2'd0;
         seq_len_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 2'd0;
         seq_len_ff <= 3'd0;
      end else if (accept) begin
         count_ff   <= count_in;
         seq_len_ff <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && write_en) begin
         pending_ff[write_idx] <= b;
      end
   end

endmodule

>>> hdl/utf8s_out.sv
module utf8s_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  utf8s_pkg::group_type grp,
   output logic                 load_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output utf8s_pkg::rsp_type   rsp_data
);

   utf8s_pkg::group_type group_ff;
   logic [2:0]           left_ff;
   logic [2:0]           left_in;
   logic [1:0]           idx_ff;
   logic [1:0]           idx_in;
   logic                 last;
   logic                 xfer;

   assign rsp_valid = (left_ff != 3'd0);
   assign last      = (left_ff == 3'd1);
   assign xfer      = rsp_valid && !rsp_stall;
   assign load_ok   = !rsp_valid || (last && !rsp_stall);

   assign rsp_data.out_byte   = group_ff.bytes[idx_ff];
   assign rsp_data.run_last   = last;
   assign rsp_data.string_end = last && group_ff.fin;

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (xfer) begin
         left_in = left_ff - 3'd1;
         idx_in  = idx_ff + 2'd1;
      end
      // take a new group once the old one drains
      if (load && grp.count != 3'd0) begin
         left_in = grp.count;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
         idx_ff  <= 2'd0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && grp.count != 3'd0) begin
         group_ff <= grp;
      end
   end

endmodule

>>> hdl/utf8_stream_sanitizer.sv
// Channel  | Direction | Ports                           | Carries
// request  | in        | req_valid, req_stall, req_data  | one text byte and end-of-string flag
// response | out       | rsp_valid, rsp_stall, rsp_data  | one sanitized byte with run/end marks
//
// A byte is decoded in the cycle it transfers; its results appear one per cycle,
// while the response side does not stall, from the next cycle on. An input causes
// 0 to 4 results; the output serializer sets the rate: one byte per cycle unless stalled.
// The request side stalls only while a multi-byte group is still draining or
// the response side stalls on the last byte of a group.
// Reset (synchronous) drops any held sequence and any undelivered results.
module utf8_stream_sanitizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  utf8s_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utf8s_pkg::rsp_type rsp_data
);

   utf8s_pkg::group_type grp;
   logic                 load_ok;
   logic                 accept;

   assign req_stall = !load_ok;
   assign accept    = req_valid && load_ok;

   utf8s_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .grp    (grp)
   );

   utf8s_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .grp       (grp),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/utf8_sanitize_checker.sv
`timescale 1ns / 1ps

module utf8_sanitize_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  utf8s_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  utf8s_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 expected_left
);

   // Predicted decoder state: held lead/continuation bytes and target length
   logic [7:0] held_bytes [3];
   logic [1:0] held_count;
   logic [2:0] held_len;

   utf8s_pkg::rsp_type sanitized_q [$];
   utf8s_pkg::rsp_type oldest;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic sanitize_byte(input utf8s_pkg::req_type r);
      logic [7:0]         b;
      logic               fin;
      logic               cont;
      logic               done;
      logic [7:0]         res [4];
      logic [2:0]         len;
      int                 k;
      int                 cnt;
      int                 i;
      utf8s_pkg::rsp_type item;
      b    = r.in_byte;
      fin  = r.is_final;
      cont = (b[7:6] == 2'b10);
      done = 1'b0;
      k    = 0;
      cnt  = held_count;
      if (held_len != 3'd0) begin
         if (cont) begin
            if (cnt + 1 == held_len) begin
               // sequence complete: pass every byte through unchanged
               for (i = 0; i < cnt; i++) begin
                  res[k] = held_bytes[i];
                  k++;
               end
               res[k] = b;
               k++;
               held_count = 2'd0;
               held_len   = 3'd0;
            end else if (fin || cnt >= 3) begin
               for (i = 0; i <= cnt; i++) begin
                  res[k] = utf8s_pkg::SUB_CHAR;
                  k++;
               end
               held_count = 2'd0;
               held_len   = 3'd0;
            end else begin
               held_bytes[cnt] = b;
               held_count      = 2'(cnt + 1);
            end
            done = 1'b1;
         end else begin
            // interrupted: replace what is held, then handle this byte afresh
            for (i = 0; i < cnt; i++) begin
               res[k] = utf8s_pkg::SUB_CHAR;
               k++;
            end
            held_count = 2'd0;
            held_len   = 3'd0;
         end
      end
      if (!done) begin
         if (!b[7]) begin
            res[k] = b;
            k++;
         end else begin
            casez (b)
               8'b110?????: len = 3'd2;
               8'b1110????: len = 3'd3;
               8'b11110???: len = 3'd4;
               default:     len = 3'd0;
            endcase
            if (len != 3'd0 && !fin) begin
               held_bytes[0] = b;
               held_count    = 2'd1;
               held_len      = len;
            end else begin
               res[k] = utf8s_pkg::SUB_CHAR;
               k++;
            end
         end
      end
      if (fin) begin
         held_count = 2'd0;
         held_len   = 3'd0;
      end
      for (i = 0; i < k; i++) begin
         item.out_byte   = res[i];
         item.run_last   = (i == k - 1);
         item.string_end = fin && (i == k - 1);
         sanitized_q.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 2'd0;
         held_len   = 3'd0;
         fail_count = 0;
         sanitized_q.delete();
         expected_left <= 0;
      end else begin
         // results at this edge belong to earlier transfers, so check first
         if (rsp_valid && !rsp_stall) begin
            if (sanitized_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, byte %02h",
                                         rsp_data.out_byte));
            end else begin
               oldest = sanitized_q.pop_front();
               if (rsp_data.out_byte !== oldest.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_data.out_byte, oldest.out_byte));
               if (rsp_data.run_last !== oldest.run_last)
                  report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                            rsp_data.run_last, oldest.run_last,
                                            oldest.out_byte));
               if (rsp_data.string_end !== oldest.string_end)
                  report_mismatch($sformatf("string_end %b, want %b (byte %02h)",
                                            rsp_data.string_end, oldest.string_end,
                                            oldest.out_byte));
            end
         end
         if (req_valid && !req_stall)
            sanitize_byte(req_data);
         expected_left <= sanitized_q.size();
      end
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   utf8s_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   utf8s_pkg::rsp_type rsp_data;

   int fail_count;
   int expected_left;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   logic [7:0] text_q [$];

   utf8_stream_sanitizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   utf8_sanitize_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= {b, fin};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // hold off the sender until every predicted result has been delivered
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   task automatic add_char();
      int         pick;
      int         len;
      int         conts;
      int         j;
      logic [7:0] r;
      pick = $urandom_range(99);
      r    = 8'($urandom);
      if (pick < 40) begin
         text_q.push_back(8'($urandom_range(1, 127)));
      end else if (pick < 80) begin
         // well-formed below 70, truncated otherwise
         len   = $urandom_range(2, 4);
         conts = (pick < 70) ? len - 1 : $urandom_range(0, len - 2);
         case (len)
            2:       text_q.push_back({3'b110, r[4:0]});
            3:       text_q.push_back({4'b1110, r[3:0]});
            default: text_q.push_back({5'b11110, r[2:0]});
         endcase
         for (j = 0; j < conts; j++) begin
            r = 8'($urandom);
            text_q.push_back({2'b10, r[5:0]});
         end
      end else if (pick < 90) begin
         text_q.push_back({2'b10, r[5:0]});
      end else begin
         text_q.push_back(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic random_strings(input int n_items);
      int stop_at;
      int chars;
      int i;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         text_q.delete();
         chars = $urandom_range(1, 8);
         for (i = 0; i < chars; i++)
            add_char();
         for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
      end
   endtask

   initial begin
      send_idle_pct = 35;
      rsp_stall_pct = 59;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // plain ASCII
      send_byte(8'h41, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b0);
      // complete 2-, 3- and 4-byte sequences
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b0);
      // stray continuations and invalid leads
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hFF, 1'b0);
      // sequence interrupted by ASCII, then by a zero byte, then by a new lead
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // lead byte at end of string, then an incomplete sequence at end
      send_byte(8'hC3, 1'b1);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h41, 1'b1);
      wait_for_drain();

      random_strings(107);
      wait_for_drain();

      send_idle_pct = 59;
      rsp_stall_pct = 35;
      random_strings(107);
      wait_for_drain();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_strings(107);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_left == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
